>>> hw/rtl/fcdh_pkg.sv
// fcdh_pkg: shared types and constants for the fan curve block
// holds the sequencer state type, register indexes and reset values
// no dependencies
package fcdh_pkg;

    localparam int DATA_W    = 8;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_LIMIT = 3'd4;

    localparam logic [DATA_W-1:0] TEMP_LOW_RST      = 8'd42;
    localparam logic [DATA_W-1:0] TEMP_HIGH_RST     = 8'd75;
    localparam logic [DATA_W-1:0] DUTY_MIN_RST      = 8'd45;
    localparam logic [DATA_W-1:0] DUTY_MAX_RST      = 8'd255;
    localparam logic [DATA_W-1:0] HOLDOFF_LIMIT_RST = 8'd6;
    localparam logic [DATA_W-1:0] LAST_DUTY_RST     = 8'd255;
    localparam logic [DATA_W-1:0] COUNT_SAT         = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage

>>> hw/rtl/fcdh_div.sv
// fcdh_div: restoring divider, one quotient bit per cycle
// 16-bit dividend by 8-bit divisor, low 8 quotient bits returned
// depends on fcdh_pkg
module fcdh_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fcdh_pkg::PROD_W-1:0]   numer,
    input  logic [fcdh_pkg::DATA_W-1:0]   denom,
    output logic                          done,
    output logic [fcdh_pkg::DATA_W-1:0]   quot
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [fcdh_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [fcdh_pkg::PROD_W-1:0]   num_reg, num_next;
    logic [fcdh_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [fcdh_pkg::DATA_W-1:0]   den_reg, den_next;
    logic [fcdh_pkg::DATA_W:0]     trial;
    logic [fcdh_pkg::DATA_W:0]     diff;
    logic                          ge;

    assign trial = {rem_reg, num_reg[fcdh_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[fcdh_pkg::PROD_W-2:0], ge};
            rem_next = ge ? diff[fcdh_pkg::DATA_W-1:0] : trial[fcdh_pkg::DATA_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {fcdh_pkg::DIV_CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg[fcdh_pkg::DATA_W-1:0];

endmodule

>>> hw/rtl/fan_curve_with_decrease_holdoff.sv
// fan_curve_with_decrease_holdoff: fan duty from temperature with a decrease hold-off
// top level: sequencer, configuration registers and output register
// depends on fcdh_pkg and fcdh_div
//
// One temperature sample is taken per request while s_tready is high; the block
// then works on it alone and drops s_tready until done. A sample that does not
// trigger a recompute goes straight back to idle; one that lands outside the
// thresholds or on a zero span goes on to the finish state; one that falls on
// the sloped part of the curve passes through the multiply stage and the 16
// single-bit steps of the restoring divider. A new duty request is sent
// only when the duty changes; it waits in an output register, and the block
// stalls only if a second change is ready before the first one has been taken.
module fan_curve_with_decrease_holdoff
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fcdh_pkg::DATA_W-1:0]       s_tdata,   // [7:0] temperature
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fcdh_pkg::DATA_W-1:0]       m_tdata,   // [7:0] duty
    input  logic                              cfg_we,
    input  logic [fcdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcdh_pkg::DATA_W-1:0]       cfg_data
);

    fcdh_pkg::state_t state_reg, state_next;

    logic [fcdh_pkg::DATA_W-1:0] temp_low_reg;
    logic [fcdh_pkg::DATA_W-1:0] temp_high_reg;
    logic [fcdh_pkg::DATA_W-1:0] duty_min_reg;
    logic [fcdh_pkg::DATA_W-1:0] duty_max_reg;
    logic [fcdh_pkg::DATA_W-1:0] holdoff_limit_reg;

    logic [fcdh_pkg::DATA_W-1:0] last_temp_reg;
    logic [fcdh_pkg::DATA_W-1:0] count_reg;
    logic [fcdh_pkg::DATA_W-1:0] last_duty_reg;
    logic                        out_valid_reg;

    logic [fcdh_pkg::DATA_W-1:0] temp_reg;
    logic [fcdh_pkg::DATA_W-1:0] duty_reg;
    logic [fcdh_pkg::DATA_W-1:0] out_data_reg;
    logic [fcdh_pkg::PROD_W-1:0] prod_reg;

    logic                        accept;
    logic                        recompute;
    logic                        rising_curve;
    logic [fcdh_pkg::DATA_W-1:0] span;
    logic [fcdh_pkg::DATA_W-1:0] offset;
    logic [fcdh_pkg::DATA_W-1:0] mag;
    logic                        changed;
    logic                        out_free;
    logic                        load_out;
    logic                        div_start;
    logic                        div_done;
    logic [fcdh_pkg::DATA_W-1:0] div_quot;

    assign accept       = s_tvalid && s_tready;
    assign recompute    = (temp_reg > last_temp_reg) || (count_reg >= holdoff_limit_reg);
    assign rising_curve = (duty_max_reg >= duty_min_reg);
    assign span         = temp_high_reg - temp_low_reg;
    assign offset       = temp_reg - temp_low_reg;
    assign mag          = rising_curve ? (duty_max_reg - duty_min_reg)
                                       : (duty_min_reg - duty_max_reg);
    assign changed      = (duty_reg != last_duty_reg);
    assign out_free     = !out_valid_reg || m_tready;
    assign load_out     = (state_reg == fcdh_pkg::ST_FINISH) && changed && out_free;

    fcdh_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcdh_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = fcdh_pkg::ST_DECIDE;
            end
            fcdh_pkg::ST_DECIDE:
            begin
                priority if (!recompute)
                    state_next = fcdh_pkg::ST_IDLE;
                else if (temp_reg > temp_high_reg || temp_reg < temp_low_reg || span == '0)
                    state_next = fcdh_pkg::ST_FINISH;
                else
                    state_next = fcdh_pkg::ST_MUL;
            end
            fcdh_pkg::ST_MUL:
                state_next = fcdh_pkg::ST_DIV_GO;
            fcdh_pkg::ST_DIV_GO:
                state_next = fcdh_pkg::ST_DIV_WAIT;
            fcdh_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = fcdh_pkg::ST_FINISH;
            end
            fcdh_pkg::ST_FINISH:
            begin
                if (!changed || out_free)
                    state_next = fcdh_pkg::ST_IDLE;
            end
            default:
                state_next = fcdh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            fcdh_pkg::ST_IDLE:     s_tready  = 1'b1;
            fcdh_pkg::ST_DIV_GO:   div_start = 1'b1;
            fcdh_pkg::ST_DECIDE,
            fcdh_pkg::ST_MUL,
            fcdh_pkg::ST_DIV_WAIT,
            fcdh_pkg::ST_FINISH:   s_tready  = 1'b0;
            default:               s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= fcdh_pkg::ST_IDLE;
            temp_low_reg      <= fcdh_pkg::TEMP_LOW_RST;
            temp_high_reg     <= fcdh_pkg::TEMP_HIGH_RST;
            duty_min_reg      <= fcdh_pkg::DUTY_MIN_RST;
            duty_max_reg      <= fcdh_pkg::DUTY_MAX_RST;
            holdoff_limit_reg <= fcdh_pkg::HOLDOFF_LIMIT_RST;
            last_temp_reg     <= '0;
            count_reg         <= '0;
            last_duty_reg     <= fcdh_pkg::LAST_DUTY_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    fcdh_pkg::CFG_TEMP_LOW:      temp_low_reg      <= cfg_data;
                    fcdh_pkg::CFG_TEMP_HIGH:     temp_high_reg     <= cfg_data;
                    fcdh_pkg::CFG_DUTY_MIN:      duty_min_reg      <= cfg_data;
                    fcdh_pkg::CFG_DUTY_MAX:      duty_max_reg      <= cfg_data;
                    fcdh_pkg::CFG_HOLDOFF_LIMIT: holdoff_limit_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            if (state_reg == fcdh_pkg::ST_DECIDE)
            begin
                if (recompute)
                begin
                    count_reg     <= '0;
                    last_temp_reg <= temp_reg;
                end
                else if (count_reg != fcdh_pkg::COUNT_SAT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (load_out)
            begin
                last_duty_reg <= duty_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            temp_reg <= s_tdata;

        if (state_reg == fcdh_pkg::ST_DECIDE)
        begin
            priority if (temp_reg > temp_high_reg)
                duty_reg <= duty_max_reg;
            else if (temp_reg < temp_low_reg)
                duty_reg <= duty_min_reg;
            else
                duty_reg <= duty_max_reg;
        end
        else if (state_reg == fcdh_pkg::ST_DIV_WAIT && div_done)
        begin
            duty_reg <= rising_curve ? (duty_min_reg + div_quot) : (duty_min_reg - div_quot);
        end

        if (state_reg == fcdh_pkg::ST_MUL)
            prod_reg <= fcdh_pkg::PROD_W'(offset) * fcdh_pkg::PROD_W'(mag);

        if (load_out)
            out_data_reg <= duty_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for fan_curve_with_decrease_holdoff
// drives temperature samples and register writes, predicts duty changes and checks them
// depends on fcdh_pkg and the fan curve RTL
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcdh_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int WALK_LEN = 215;
    localparam int MAX_PRINTS = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = 3'd7;

    typedef enum int {PACE_FULL, PACE_SHORT, PACE_MIXED} pace_t;
    typedef enum int {SEG_RISE, SEG_FALL, SEG_JITTER, SEG_NOISE} seg_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DATA_W-1:0] s_tdata = '0;     // [7:0] temperature
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // [7:0] duty
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // curve registers and tracked state
    logic [DATA_W-1:0] temp_lo_r = TEMP_LOW_RST;
    logic [DATA_W-1:0] temp_hi_r = TEMP_HIGH_RST;
    logic [DATA_W-1:0] duty_lo_r = DUTY_MIN_RST;
    logic [DATA_W-1:0] duty_hi_r = DUTY_MAX_RST;
    logic [DATA_W-1:0] hold_limit_r = HOLDOFF_LIMIT_RST;
    logic [DATA_W-1:0] seen_temp = '0;
    logic [DATA_W-1:0] hold_count = '0;
    logic [DATA_W-1:0] shown_duty = LAST_DUTY_RST;

    logic [DATA_W-1:0] temp_feed[$];
    logic [DATA_W-1:0] duty_changes[$];

    pace_t pace = PACE_MIXED;
    bit req_taken = 1'b0;
    bit duty_taken = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_cycles = 0;
    int fail_count = 0;
    int samples_done = 0;
    int duties_done = 0;
    int settings_done = 0;

    fan_curve_with_decrease_holdoff DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] curve_duty(logic [DATA_W-1:0] t);
        int span;
        int off;
        int mag;
        if (t > temp_hi_r)
            return duty_hi_r;
        if (t < temp_lo_r)
            return duty_lo_r;
        if (temp_hi_r == temp_lo_r)
            return duty_hi_r;
        span = int'(temp_hi_r) - int'(temp_lo_r);
        off = int'(t) - int'(temp_lo_r);
        if (duty_hi_r >= duty_lo_r)
        begin
            mag = int'(duty_hi_r) - int'(duty_lo_r);
            return DATA_W'(int'(duty_lo_r) + (off * mag) / span);
        end
        mag = int'(duty_lo_r) - int'(duty_hi_r);
        return DATA_W'(int'(duty_lo_r) - (off * mag) / span);
    endfunction

    task automatic track_sample(logic [DATA_W-1:0] t);
        logic [DATA_W-1:0] d;
        if (t > seen_temp || hold_count >= hold_limit_r)
        begin
            hold_count = '0;
            seen_temp = t;
            d = curve_duty(t);
            if (d != shown_duty)
            begin
                shown_duty = d;
                duty_changes.push_back(d);
            end
        end
        else if (hold_count < COUNT_SAT)
        begin
            hold_count = hold_count + 1'b1;
        end
    endtask

    task automatic report_mismatch(string what);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (pace == PACE_FULL || r < 55)
            return 0;
        if (pace == PACE_SHORT || r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        logic [DATA_W-1:0] want;
        if (rst_n)
        begin
            req_taken = s_tvalid && s_tready;
            duty_taken = m_tvalid && m_tready;
            if (req_taken)
            begin
                track_sample(s_tdata);
                samples_done++;
            end
            if (duty_taken)
            begin
                if (duty_changes.size() == 0)
                begin
                    report_mismatch($sformatf("duty %0d with no change pending", m_tdata));
                end
                else
                begin
                    want = duty_changes.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("duty %0d, predicted %0d", m_tdata, want));
                    duties_done++;
                end
            end
            stall_cycles = (req_taken || duty_taken) ? 0 : stall_cycles + 1;
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (gap_left > 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left--;
                end
                else if (temp_feed.size() > 0)
                begin
                    s_tdata <= temp_feed.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_left == 0 && (duty_taken || $urandom_range(0, 15) == 0))
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_TEMP_LOW:      temp_lo_r = val;
            CFG_TEMP_HIGH:     temp_hi_r = val;
            CFG_DUTY_MIN:      duty_lo_r = val;
            CFG_DUTY_MAX:      duty_hi_r = val;
            CFG_HOLDOFF_LIMIT: hold_limit_r = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_curve(int lo, int hi, int dlo, int dhi, int lim);
        set_reg(CFG_TEMP_LOW, DATA_W'(lo));
        set_reg(CFG_TEMP_HIGH, DATA_W'(hi));
        set_reg(CFG_DUTY_MIN, DATA_W'(dlo));
        set_reg(CFG_DUTY_MAX, DATA_W'(dhi));
        set_reg(CFG_HOLDOFF_LIMIT, DATA_W'(lim));
        settings_done++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (temp_feed.size() > 0 || s_tvalid || duty_changes.size() > 0);
        // a sample with no duty change may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic feed_list(int vals[$]);
        foreach (vals[i])
            temp_feed.push_back(DATA_W'(vals[i]));
    endtask

    // rising and falling ramps and jitter with random content, plus some noise
    task automatic feed_walk(int n);
        int t;
        int len;
        int pushed;
        seg_kind_t kind;
        t = $urandom_range(0, 255);
        pushed = 0;
        while (pushed < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = SEG_RISE;
                3, 4, 5, 6: kind = SEG_FALL;
                7, 8: kind = SEG_JITTER;
                default: kind = SEG_NOISE;
            endcase
            len = $urandom_range(1, 20);
            for (int j = 0; j < len && pushed < n; j++)
            begin
                case (kind)
                    SEG_RISE:   t = t + $urandom_range(0, 5);
                    SEG_FALL:   t = t - $urandom_range(0, 3);
                    SEG_JITTER: t = t + $urandom_range(0, 4) - 2;
                    default:    t = $urandom_range(0, 255);
                endcase
                if (t < 0)
                    t = 0;
                if (t > 255)
                    t = 255;
                temp_feed.push_back(DATA_W'(t));
                pushed++;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset curve: slope, top, bottom after the hold-off runs out
        pace = PACE_MIXED;
        feed_list('{60, 76, 255, 0, 0, 0, 0, 0, 0, 0, 42});
        wait_idle();

        // zero span, zero hold-off, writes to unused indexes
        load_curve(100, 100, 0, 200, 0);
        set_reg(CFG_SPARE_FIRST, '0);
        set_reg(CFG_SPARE_LAST, 8'hff);
        feed_list('{100, 99, 101, 0, 255});
        wait_idle();

        // crossed thresholds, then a falling curve
        load_curve(200, 50, 255, 0, 0);
        feed_list('{100, 51, 50, 255});
        wait_idle();
        load_curve(0, 255, 255, 0, 1);
        feed_list('{0, 128, 255, 17});
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pace = pace_t'(p % 3);
            case (p)
                0: load_curve(0, 255, 0, 255, 255);
                1: load_curve(255, 0, 255, 0, 0);
                2: load_curve(0, 0, 0, 0, 0);
                3: load_curve(255, 255, 255, 255, 255);
                default:
                begin
                    int lo;
                    int hi;
                    lo = $urandom_range(0, 200);
                    hi = lo + $urandom_range(0, 55);
                    if ($urandom_range(0, 7) == 0)
                        hi = $urandom_range(0, 255);
                    load_curve(lo, hi, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 12));
                end
            endcase
            if (p == 0)
            begin
                // long non-rising run drives the hold-off count to its ceiling
                temp_feed.push_back(8'd200);
                repeat (256) temp_feed.push_back(8'd100);
            end
            feed_walk(WALK_LEN);
            wait_idle();
        end

        $display("ran %0d temperature samples over %0d register settings", samples_done,
                 settings_done + 1);
        $display("checked %0d duty changes, %0d mismatches", duties_done, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fcdh_pkg.sv
hw/rtl/fcdh_div.sv
hw/rtl/fan_curve_with_decrease_holdoff.sv
bench/tb_top.sv
